### hdl/rcm_pkg.sv
`timescale 1ns / 1ps
package rcm_pkg;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int TRIG_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int Q = 30;
  localparam int ZW = 36;          // Q.30 angle range plus headroom
  localparam int XW = 33;          // CORDIC x/y width, |x|,|y| < 2^31
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    unique case (i)
      0: r = 36'sd843314856;   1: r = 36'sd497837829;
      2: r = 36'sd263043836;   3: r = 36'sd133525158;
      4: r = 36'sd67021686;    5: r = 36'sd33543515;
      6: r = 36'sd16775850;    7: r = 36'sd8388437;
      8: r = 36'sd4194282;     9: r = 36'sd2097149;
      10: r = 36'sd1048575;    11: r = 36'sd524287;
      12: r = 36'sd262143;     13: r = 36'sd131071;
      14: r = 36'sd65535;      15: r = 36'sd32767;
      16: r = 36'sd16383;      17: r = 36'sd8191;
      18: r = 36'sd4095;       19: r = 36'sd2047;
      20: r = 36'sd1023;       21: r = 36'sd511;
      22: r = 36'sd255;        23: r = 36'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

### hdl/rcm_trig.sv
`timescale 1ns / 1ps
// Pipelined CORDIC: one register stage for quadrant reduction, one per iteration.
module rcm_trig #(
  parameter int ANGLE_WIDTH = rcm_pkg::ANGLE_WIDTH_DEF,
  parameter int TRIG_STAGES = rcm_pkg::TRIG_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [ANGLE_WIDTH-1:0]      angle,
  output logic signed [rcm_pkg::XW-1:0]      cos_q,
  output logic signed [rcm_pkg::XW-1:0]      sin_q
);
  import rcm_pkg::*;
  localparam int NS = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
  localparam int SH = 33 - ANGLE_WIDTH;

  logic signed [XW-1:0] x_r [NS+1];
  logic signed [XW-1:0] y_r [NS+1];
  logic signed [ZW-1:0] z_r [NS+1];
  logic                 neg_r [NS+1];
  logic signed [ZW-1:0] z0;

  assign z0 = ZW'(angle) <<< SH;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      if (z0 > HALF_PI_Q30) begin
        z_r[0] <= z0 - PI_Q30; neg_r[0] <= 1'b1;
      end else if (z0 < -HALF_PI_Q30) begin
        z_r[0] <= z0 + PI_Q30; neg_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z0; neg_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_st
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(i);
        end
      end
    end
  end

  assign cos_q = neg_r[NS] ? -x_r[NS] : x_r[NS];
  assign sin_q = neg_r[NS] ? -y_r[NS] : y_r[NS];
endmodule

### hdl/rcm_coef.sv
`timescale 1ns / 1ps
// cc, cs, ss rounded to Q.CF; multiply stage then rounding stage.
module rcm_coef #(
  parameter int CF = 28
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [rcm_pkg::XW-1:0] cos_q,
  input  logic signed [rcm_pkg::XW-1:0] sin_q,
  output logic signed [CF+2:0]          cc,
  output logic signed [CF+2:0]          cs,
  output logic signed [CF+2:0]          ss
);
  import rcm_pkg::*;
  localparam int PW = 2 * XW;
  localparam int SHF = 60 - CF;
  logic signed [PW-1:0] pcc_r, pcs_r, pss_r;
  logic signed [PW-1:0] half;

  assign half = PW'(1) <<< (SHF - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      pcc_r <= cos_q * cos_q;
      pcs_r <= cos_q * sin_q;
      pss_r <= sin_q * sin_q;
      cc <= (CF+3)'((pcc_r + half) >>> SHF);
      cs <= (CF+3)'((pcs_r + half) >>> SHF);
      ss <= (CF+3)'((pss_r + half) >>> SHF);
    end
  end
endmodule

### hdl/rcm_lane.sv
`timescale 1ns / 1ps
// One element lane: four products, registered, then sum, round and saturate.
module rcm_lane #(
  parameter int DATA_WIDTH = rcm_pkg::DATA_WIDTH_DEF,
  parameter int CF = 28
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [CF+2:0]         k0, k1, k2, k3,
  input  logic signed [DATA_WIDTH-1:0] v0, v1, v2, v3,
  output logic signed [DATA_WIDTH-1:0] res
);
  localparam int PW = CF + 3 + DATA_WIDTH;
  localparam int SW = PW + 2;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [SW-1:0] sum, rnd;
  localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [SW-1:0] LO = -HI - 1;

  assign sum = SW'(p0_r) + SW'(p1_r) + SW'(p2_r) + SW'(p3_r);
  assign rnd = (sum + (SW'(1) <<< (CF-1))) >>> CF;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= k0 * v0;
      p1_r <= k1 * v1;
      p2_r <= k2 * v2;
      p3_r <= k3 * v3;
      if (rnd > HI)      res <= HI[DATA_WIDTH-1:0];
      else if (rnd < LO) res <= LO[DATA_WIDTH-1:0];
      else               res <= rnd[DATA_WIDTH-1:0];
    end
  end
endmodule

### hdl/rotate_complex_matrix_2x2_unit.sv
`timescale 1ns / 1ps
// Rotation similarity transform R(a)*A*R(-a) of a complex 2x2 matrix. Takes one
// item per clock while not stalled. NS is TRIG_STAGES capped at the 24
// arctangent entries (16 by default). Registered in order: quadrant reduction,
// each CORDIC iteration, the coefficient products and their rounding, the
// products and result of the eight element lanes, the output register. The
// pipeline freezes as a whole when the result register is full and stalled, so
// the input stall equals out_valid & out_stall. No reset on the data path.
module rotate_complex_matrix_2x2_unit #(
  parameter int DATA_WIDTH  = rcm_pkg::DATA_WIDTH_DEF,
  parameter int ANGLE_WIDTH = rcm_pkg::ANGLE_WIDTH_DEF,
  parameter int TRIG_STAGES = rcm_pkg::TRIG_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_WIDTH-1:0] in_angle,
  input  logic signed [DATA_WIDTH-1:0] in_a00_re, in_a00_im, in_a01_re, in_a01_im,
  input  logic signed [DATA_WIDTH-1:0] in_a10_re, in_a10_im, in_a11_re, in_a11_im,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_r00_re, out_r00_im, out_r01_re, out_r01_im,
  output logic signed [DATA_WIDTH-1:0] out_r10_re, out_r10_im, out_r11_re, out_r11_im
);
  import rcm_pkg::*;
  localparam int NS = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
  localparam int CF = ((60 - DATA_WIDTH) < 30) ? (60 - DATA_WIDTH) : 30;
  localparam int DLY = NS + 3;   // matrix delay to line up with coefficients
  localparam int LAT = NS + 5;   // valid pipe up to lane outputs

  logic en;
  logic [LAT-1:0] vld_r;
  logic signed [XW-1:0] c_q, s_q;
  logic signed [CF+2:0] cc, cs, ss, ncs, nss;
  logic signed [DATA_WIDTH-1:0] m_r [DLY][8];
  logic signed [DATA_WIDTH-1:0] lane_o [8];

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (en) out_valid <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0][0] <= in_a00_re; m_r[0][1] <= in_a00_im;
      m_r[0][2] <= in_a01_re; m_r[0][3] <= in_a01_im;
      m_r[0][4] <= in_a10_re; m_r[0][5] <= in_a10_im;
      m_r[0][6] <= in_a11_re; m_r[0][7] <= in_a11_im;
      for (int d = 1; d < DLY; d++) m_r[d] <= m_r[d-1];
    end
  end

  rcm_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_trig (
    .clk(clk), .en(en), .angle(in_angle), .cos_q(c_q), .sin_q(s_q));

  rcm_coef #(.CF(CF)) u_coef (
    .clk(clk), .en(en), .cos_q(c_q), .sin_q(s_q), .cc(cc), .cs(cs), .ss(ss));

  assign ncs = -cs;
  assign nss = -ss;

  // lanes: p = 0 real, 1 imaginary; element index 0 a00, 2 a01, 4 a10, 6 a11
  for (genvar p = 0; p < 2; p++) begin : g_part
    rcm_lane #(.DATA_WIDTH(DATA_WIDTH), .CF(CF)) u_r00 (.clk(clk), .en(en),
      .k0(cc), .k1(ncs), .k2(ncs), .k3(ss),
      .v0(m_r[DLY-1][p]), .v1(m_r[DLY-1][4+p]), .v2(m_r[DLY-1][2+p]),
      .v3(m_r[DLY-1][6+p]), .res(lane_o[p]));
    rcm_lane #(.DATA_WIDTH(DATA_WIDTH), .CF(CF)) u_r01 (.clk(clk), .en(en),
      .k0(cs), .k1(nss), .k2(cc), .k3(ncs),
      .v0(m_r[DLY-1][p]), .v1(m_r[DLY-1][4+p]), .v2(m_r[DLY-1][2+p]),
      .v3(m_r[DLY-1][6+p]), .res(lane_o[2+p]));
    rcm_lane #(.DATA_WIDTH(DATA_WIDTH), .CF(CF)) u_r10 (.clk(clk), .en(en),
      .k0(cs), .k1(cc), .k2(nss), .k3(ncs),
      .v0(m_r[DLY-1][p]), .v1(m_r[DLY-1][4+p]), .v2(m_r[DLY-1][2+p]),
      .v3(m_r[DLY-1][6+p]), .res(lane_o[4+p]));
    rcm_lane #(.DATA_WIDTH(DATA_WIDTH), .CF(CF)) u_r11 (.clk(clk), .en(en),
      .k0(ss), .k1(cs), .k2(cs), .k3(cc),
      .v0(m_r[DLY-1][p]), .v1(m_r[DLY-1][4+p]), .v2(m_r[DLY-1][2+p]),
      .v3(m_r[DLY-1][6+p]), .res(lane_o[6+p]));
  end

  // merge: the result register collects all eight lanes
  always_ff @(posedge clk) begin
    if (en) begin
      out_r00_re <= lane_o[0]; out_r00_im <= lane_o[1];
      out_r01_re <= lane_o[2]; out_r01_im <= lane_o[3];
      out_r10_re <= lane_o[4]; out_r10_im <= lane_o[5];
      out_r11_re <= lane_o[6]; out_r11_im <= lane_o[7];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_r00_re) && $stable(out_r11_im))
    else $error("result changed while stalled");
  a_frz: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline moved while frozen");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
endmodule
